[sv/cem_pkg.sv]
package cem_pkg;

  // Default sizing of the block.
  localparam int NUM_QUEUES_DEF = 8;
  localparam int TIME_SHIFT_DEF = 10;

  // Field widths fixed by the interface.
  localparam int QIDX_W     = 3;
  localparam int NS_W       = 63;
  localparam int BYTES_W    = 24;
  localparam int UNIT_W     = 32;
  localparam int INV_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Depth of the small queues between the parts of the block.
  localparam int QDEPTH = 2;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY_TARGET     = 2'd0,
    CFG_CONTROL_INTERVAL = 2'd1,
    CFG_MIN_BACKLOG      = 2'd2
  } cfg_index_t;

  // Configuration reset values.
  localparam logic [UNIT_W-1:0]  DELAY_TARGET_RST     = 32'd4883;
  localparam logic [UNIT_W-1:0]  CONTROL_INTERVAL_RST = 32'd97656;
  localparam logic [BYTES_W-1:0] MIN_BACKLOG_RST      = 24'd1538;

  // Fixed-point constants of the control law and the Newton step.
  localparam logic [INV_W-1:0] INV_SQRT_ONE    = 16'hFFFF;
  localparam logic [48:0]      NEWTON_THREE    = 49'h3_0000_0000;
  localparam int               REACH_SHIFT     = 4;

  // Sequencer states of the decision engine.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_READ,
    ST_NEWT1,
    ST_NEWT2,
    ST_NEWT3,
    ST_NEWT4,
    ST_NEWT5,
    ST_NEWT6,
    ST_LAWI,
    ST_LAW,
    ST_DONE
  } cem_state_t;

  // One classified packet, handed from the front to the back.
  typedef struct packed {
    logic              qok;
    logic [QIDX_W-1:0] queue;
    logic [UNIT_W-1:0] now;
    logic [UNIT_W-1:0] soj;
    logic              backlog_low;
  } cem_item_t;

  // Per-queue CoDel state, one memory word per queue.
  typedef struct packed {
    logic [UNIT_W-1:0] count;
    logic [UNIT_W-1:0] prev;
    logic              active;
    logic [INV_W-1:0]  inv;
    logic [UNIT_W-1:0] above;
    logic [UNIT_W-1:0] next;
    logic [UNIT_W-1:0] last;
  } cem_qstate_t;

  // One decision beat on the result side.
  typedef struct packed {
    logic              mark;
    logic [UNIT_W-1:0] soj;
  } cem_result_t;

  // Wrapping time order: a is before b when a - b is negative.
  function automatic logic t_before(input logic [UNIT_W-1:0] a, input logic [UNIT_W-1:0] b);
    logic [UNIT_W-1:0] d;
    d = a - b;
    return d[UNIT_W-1];
  endfunction

  // Wrapping time order: a is after b when a - b is positive.
  function automatic logic t_after(input logic [UNIT_W-1:0] a, input logic [UNIT_W-1:0] b);
    logic [UNIT_W-1:0] d;
    d = a - b;
    return (d != '0) && !d[UNIT_W-1];
  endfunction

endpackage

[sv/cem_fifo.sv]
module cem_fifo #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_en,
  input  logic [WIDTH-1:0] wr_data,
  output logic             full,
  input  logic             rd_en,
  output logic [WIDTH-1:0] rd_data,
  output logic             empty
);
  import cem_pkg::*;

  localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;

  logic [WIDTH-1:0] slots [QDEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [PW:0]      level;
  logic             do_wr;
  logic             do_rd;

  assign full    = (level == (PW+1)'(QDEPTH));
  assign empty   = (level == '0);
  assign do_wr   = wr_en && !full;
  assign do_rd   = rd_en && !empty;
  assign rd_data = slots[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      level  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(QDEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(QDEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_wr && !do_rd) begin
        level <= level + 1'b1;
      end else if (do_rd && !do_wr) begin
        level <= level - 1'b1;
      end
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_data;
    end
  end

endmodule

[sv/cem_ram.sv]
module cem_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/cem_front.sv]
module cem_front #(
  parameter int NUM_QUEUES = cem_pkg::NUM_QUEUES_DEF,
  parameter int TIME_SHIFT = cem_pkg::TIME_SHIFT_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         push,
  output logic                         full,
  input  logic [cem_pkg::QIDX_W-1:0]   queue_index,
  input  logic [cem_pkg::NS_W-1:0]     time_now_ns,
  input  logic [cem_pkg::NS_W-1:0]     enqueue_time_ns,
  input  logic [cem_pkg::BYTES_W-1:0]  backlog_bytes,
  input  logic [cem_pkg::BYTES_W-1:0]  min_backlog_bytes,
  output cem_pkg::cem_item_t           head_item,
  output logic                         head_empty,
  input  logic                         head_pop
);
  import cem_pkg::*;

  localparam int IW = $bits(cem_item_t);

  logic [NS_W:0]   diff;
  cem_item_t       item;
  logic [IW-1:0]   head_bits;

  // Sojourn in CoDel units; a negative difference saturates to zero.
  assign diff = {1'b0, time_now_ns} - {1'b0, enqueue_time_ns};

  always_comb begin
    item.qok         = (32'(queue_index) < NUM_QUEUES);
    item.queue       = queue_index;
    item.now         = UNIT_W'(time_now_ns >> TIME_SHIFT);
    item.soj         = diff[NS_W] ? '0 : UNIT_W'(diff[NS_W-1:0] >> TIME_SHIFT);
    item.backlog_low = (backlog_bytes <= min_backlog_bytes);
  end

  // Classified packets wait here for the decision engine.
  cem_fifo #(.WIDTH(IW)) u_item_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (push),
    .wr_data (item),
    .full    (full),
    .rd_en   (head_pop),
    .rd_data (head_bits),
    .empty   (head_empty)
  );

  assign head_item = cem_item_t'(head_bits);

endmodule

[sv/cem_back.sv]
module cem_back #(
  parameter int NUM_QUEUES = cem_pkg::NUM_QUEUES_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic [cem_pkg::UNIT_W-1:0]  delay_target,
  input  logic [cem_pkg::UNIT_W-1:0]  control_interval,
  input  cem_pkg::cem_item_t          in_item,
  input  logic                        in_empty,
  output logic                        in_pop,
  output cem_pkg::cem_result_t        out_result,
  output logic                        out_push,
  input  logic                        out_full
);
  import cem_pkg::*;

  localparam int AW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int SW = $bits(cem_qstate_t);

  cem_state_t        state;
  cem_state_t        state_next;
  cem_item_t         item;
  cem_qstate_t       work;
  cem_qstate_t       st_rd;
  cem_qstate_t       st_new;
  logic [NUM_QUEUES-1:0] qvalid;
  logic [SW-1:0]     ram_rdata;
  logic [AW-1:0]     rd_addr;
  logic [AW-1:0]     wr_addr;
  logic              ram_we;
  logic              mark;
  logic [UNIT_W-1:0] law_base;
  logic [46:0]       vv;
  logic [47:0]       lo_prod;
  logic [63:0]       mul_p;
  logic [UNIT_W-1:0] mul_a;
  logic [UNIT_W-1:0] mul_b;
  logic              d_mark;
  logic              d_newton;
  logic              d_ok;
  logic [UNIT_W-1:0] d_base;
  logic [UNIT_W-1:0] delta;
  logic [48:0]       w49;
  logic [46:0]       sum47;

  assign rd_addr = AW'({{AW{1'b0}}, in_item.queue});
  assign wr_addr = AW'({{AW{1'b0}}, item.queue});

  // Per-queue state store; a queue never written reads as all zero.
  cem_ram #(.WIDTH(SW), .DEPTH(NUM_QUEUES)) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_addr),
    .wdata (work),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign st_rd = qvalid[wr_addr] ? cem_qstate_t'(ram_rdata) : '0;

  // Target and interval rules, then the marking decision.
  always_comb begin
    st_new   = st_rd;
    d_ok     = 1'b0;
    d_mark   = 1'b0;
    d_newton = 1'b0;
    d_base   = item.now;
    delta    = st_rd.count - st_rd.prev;
    st_new.last = item.soj;
    if (t_before(item.soj, delay_target) || item.backlog_low) begin
      st_new.above = '0;
    end else if (st_rd.above == '0) begin
      st_new.above = item.now + control_interval;
    end else begin
      d_ok = t_after(item.now, st_rd.above);
    end
    if (st_rd.active) begin
      if (!d_ok) begin
        st_new.active = 1'b0;
      end else if (!t_before(item.now, st_rd.next)) begin
        st_new.count = st_rd.count + 1'b1;
        d_newton     = 1'b1;
        d_mark       = 1'b1;
        d_base       = st_rd.next;
      end
    end else if (d_ok) begin
      d_mark        = 1'b1;
      st_new.active = 1'b1;
      if ((delta > 32'd1) &&
          t_before(item.now - st_rd.next, control_interval << REACH_SHIFT)) begin
        st_new.count = delta;
        d_newton     = 1'b1;
      end else begin
        st_new.count = 32'd1;
        st_new.inv   = INV_SQRT_ONE;
      end
      st_new.prev = st_new.count;
    end
  end

  // Newton step pieces: 3 - count * inv^2, then times inv.
  assign w49   = NEWTON_THREE - mul_p[48:0];
  assign sum47 = lo_prod[46:0] + {mul_p[14:0], 32'd0};

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state, handshakes and multiplier operands.
  always_comb begin
    state_next = state;
    in_pop     = 1'b0;
    out_push   = 1'b0;
    ram_we     = 1'b0;
    mul_a      = '0;
    mul_b      = '0;
    case (state)
      ST_IDLE: begin
        if (!in_empty && !out_full) begin
          in_pop     = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        if (!item.qok || !d_mark) begin
          state_next = ST_DONE;
        end else if (d_newton) begin
          state_next = ST_NEWT1;
        end else begin
          state_next = ST_LAWI;
        end
      end
      ST_NEWT1: begin
        mul_a      = UNIT_W'(work.inv);
        mul_b      = UNIT_W'(work.inv);
        state_next = ST_NEWT2;
      end
      ST_NEWT2: begin
        mul_a      = work.count;
        mul_b      = mul_p[31:0];
        state_next = ST_NEWT3;
      end
      ST_NEWT3: begin
        state_next = ST_NEWT4;
      end
      ST_NEWT4: begin
        mul_a      = vv[31:0];
        mul_b      = UNIT_W'(work.inv);
        state_next = ST_NEWT5;
      end
      ST_NEWT5: begin
        mul_a      = UNIT_W'(vv[46:32]);
        mul_b      = UNIT_W'(work.inv);
        state_next = ST_NEWT6;
      end
      ST_NEWT6: begin
        state_next = ST_LAWI;
      end
      ST_LAWI: begin
        mul_a      = control_interval;
        mul_b      = UNIT_W'(work.inv);
        state_next = ST_LAW;
      end
      ST_LAW: begin
        state_next = ST_DONE;
      end
      ST_DONE: begin
        out_push   = 1'b1;
        ram_we     = item.qok;
        state_next = ST_IDLE;
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Working registers and the shared multiplier.
  always_ff @(posedge clk) begin
    mul_p <= 64'(mul_a) * 64'(mul_b);
    case (state)
      ST_IDLE: begin
        if (in_pop) begin
          item <= in_item;
        end
      end
      ST_READ: begin
        if (item.qok) begin
          work <= st_new;
        end
        mark     <= item.qok && d_mark;
        law_base <= d_base;
      end
      ST_NEWT3: begin
        vv <= w49[48:2];
      end
      ST_NEWT5: begin
        lo_prod <= mul_p[47:0];
      end
      ST_NEWT6: begin
        work.inv <= sum47[46:31];
      end
      ST_LAW: begin
        work.next <= law_base + mul_p[47:16];
      end
      default: begin
      end
    endcase
  end

  // A queue's entry becomes valid once its state has been written.
  always_ff @(posedge clk) begin
    if (rst) begin
      qvalid <= '0;
    end else if (ram_we) begin
      qvalid[wr_addr] <= 1'b1;
    end
  end

  assign out_result.mark = mark;
  assign out_result.soj  = item.soj;

endmodule

[sv/codel_ecn_marker_unit.sv]
// A packet runs IDLE, READ, DONE with no mark; marking afresh adds LAWI and LAW, and a
// Newton step refining the inverse square root adds NEWT1 to NEWT6 before those. A new
// packet is taken only in IDLE, with the result queue not full. The Newton step and
// control law share one registered 32x32 multiplier.
// Reset (synchronous, active high) empties both queues, idles the sequencer, restores
// the register defaults and marks every queue's state as zero; no clearing pass.
module codel_ecn_marker_unit #(
  parameter int NUM_QUEUES = cem_pkg::NUM_QUEUES_DEF,
  parameter int TIME_SHIFT = cem_pkg::TIME_SHIFT_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  output logic                           full,
  input  logic [cem_pkg::QIDX_W-1:0]     queue_index,
  input  logic [cem_pkg::NS_W-1:0]       time_now_ns,
  input  logic [cem_pkg::NS_W-1:0]       enqueue_time_ns,
  input  logic [cem_pkg::BYTES_W-1:0]    backlog_bytes,
  output logic                           empty,
  input  logic                           pop,
  output logic                           ecn_mark,
  output logic [cem_pkg::UNIT_W-1:0]     sojourn_units,
  input  logic                           cfg_we,
  input  logic [cem_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [cem_pkg::CFG_DATA_W-1:0] cfg_data
);
  import cem_pkg::*;

  localparam int RW = $bits(cem_result_t);

  logic [UNIT_W-1:0]  delay_target;
  logic [UNIT_W-1:0]  control_interval;
  logic [BYTES_W-1:0] min_backlog_bytes;
  cem_item_t          head_item;
  logic               head_empty;
  logic               head_pop;
  cem_result_t        res_in;
  logic               res_push;
  logic               res_full;
  logic [RW-1:0]      res_bits;
  cem_result_t        res_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      delay_target      <= DELAY_TARGET_RST;
      control_interval  <= CONTROL_INTERVAL_RST;
      min_backlog_bytes <= MIN_BACKLOG_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_DELAY_TARGET:     delay_target      <= cfg_data;
        CFG_CONTROL_INTERVAL: control_interval  <= cfg_data;
        CFG_MIN_BACKLOG:      min_backlog_bytes <= cfg_data[BYTES_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Front: classify each packet and queue it.
  cem_front #(.NUM_QUEUES(NUM_QUEUES), .TIME_SHIFT(TIME_SHIFT)) u_front (
    .clk               (clk),
    .rst               (rst),
    .push              (push),
    .full              (full),
    .queue_index       (queue_index),
    .time_now_ns       (time_now_ns),
    .enqueue_time_ns   (enqueue_time_ns),
    .backlog_bytes     (backlog_bytes),
    .min_backlog_bytes (min_backlog_bytes),
    .head_item         (head_item),
    .head_empty        (head_empty),
    .head_pop          (head_pop)
  );

  // Back: per-queue CoDel decision.
  cem_back #(.NUM_QUEUES(NUM_QUEUES)) u_back (
    .clk              (clk),
    .rst              (rst),
    .delay_target     (delay_target),
    .control_interval (control_interval),
    .in_item          (head_item),
    .in_empty         (head_empty),
    .in_pop           (head_pop),
    .out_result       (res_in),
    .out_push         (res_push),
    .out_full         (res_full)
  );

  // Results wait here until the consumer takes them.
  cem_fifo #(.WIDTH(RW)) u_result_q (
    .clk     (clk),
    .rst     (rst),
    .wr_en   (res_push),
    .wr_data (res_in),
    .full    (res_full),
    .rd_en   (pop),
    .rd_data (res_bits),
    .empty   (empty)
  );

  assign res_out       = cem_result_t'(res_bits);
  assign ecn_mark      = res_out.mark;
  assign sojourn_units = res_out.soj;

endmodule

[sv/cem_checker.sv]
module cem_checker (
  input logic        clk,
  input logic        rst,
  input logic        push,
  input logic        full,
  input logic        pop,
  input logic        empty,
  input logic        ecn_mark,
  input logic [31:0] sojourn_units
);

  // Reset leaves both sides idle.
  a_reset_idle: assert property (@(posedge clk) rst |=> (empty && !full))
    else $error("queues not idle after reset");

  // The input side fills up only on an accepted beat.
  a_full_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(full) |-> ($past(push) || $past(rst)))
    else $error("full rose without an accepted input beat");

  // The result side drains only on an accepted beat.
  a_empty_rise: assert property (@(posedge clk) disable iff (rst)
    $rose(empty) |-> ($past(pop) || $past(rst)))
    else $error("empty rose without an accepted result beat");

  // A waiting result holds until it is taken.
  a_result_hold: assert property (@(posedge clk) disable iff (rst)
    (!empty && !pop) |=> (!empty && $stable(ecn_mark) && $stable(sojourn_units)))
    else $error("waiting result changed before it was taken");

endmodule

bind codel_ecn_marker_unit cem_checker u_checker (.*);
